/* rtl/core/i2cdiv_pkg.sv */
`default_nettype none

package i2cdiv_pkg;

    localparam int unsigned CLK_W     = 30;
    localparam int unsigned RATE_W    = 26;
    localparam int unsigned DIVISOR_W = 15;
    localparam int unsigned CNT_W     = 5;
    localparam int unsigned PC_W      = 3;

    localparam logic [CLK_W-1:0] CLK_RESET  = 30'd100000000;
    localparam logic [CNT_W-1:0] DIV_LAST   = 5'd29;
    localparam logic [3:0]       DEFAULT_M  = 4'd5;
    localparam logic [2:0]       DEFAULT_N  = 3'd0;

    typedef enum logic [2:0] {
        OP_NOP  = 3'd0,
        OP_LOAD = 3'd1,
        OP_DIV  = 3'd2,
        OP_CMP  = 3'd3,
        OP_STEP = 3'd4,
        OP_EMIT = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        COND_NEXT       = 3'd0,
        COND_IDLE       = 3'd1,
        COND_DIV_MORE   = 3'd2,
        COND_MORE_CANDS = 3'd3,
        COND_ALWAYS     = 3'd4
    } cond_t;

    localparam logic [PC_W-1:0] STEP_IDLE = 3'd0;
    localparam logic [PC_W-1:0] STEP_DIV  = 3'd1;
    localparam logic [PC_W-1:0] STEP_CMP  = 3'd2;
    localparam logic [PC_W-1:0] STEP_NEXT = 3'd3;
    localparam logic [PC_W-1:0] STEP_EMIT = 3'd4;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        op_t op;
    } ctrl_t;

    typedef struct packed {
        logic div_more;
        logic more_cands;
    } status_t;

    // microprogram
    function automatic uword_t rom_f(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: STEP_IDLE};
        unique case (pc)
            STEP_IDLE: w = '{op: OP_LOAD, cond: COND_IDLE,       target: STEP_IDLE};
            STEP_DIV:  w = '{op: OP_DIV,  cond: COND_DIV_MORE,   target: STEP_DIV};
            STEP_CMP:  w = '{op: OP_CMP,  cond: COND_NEXT,       target: STEP_IDLE};
            STEP_NEXT: w = '{op: OP_STEP, cond: COND_MORE_CANDS, target: STEP_DIV};
            STEP_EMIT: w = '{op: OP_EMIT, cond: COND_ALWAYS,     target: STEP_IDLE};
            default:   w = '{op: OP_NOP,  cond: COND_ALWAYS,     target: STEP_IDLE};
        endcase
        return w;
    endfunction

    // 10 * (m + 1) * 2^n
    function automatic logic [DIVISOR_W-1:0] divisor_f(input logic [3:0] m,
                                                       input logic [2:0] n);
        logic [4:0]           mp1;
        logic [7:0]           base;
        logic [DIVISOR_W-1:0] wide;
        mp1  = {1'b0, m} + 5'd1;
        base = ({3'b000, mp1} << 3) + ({3'b000, mp1} << 1);
        wide = {7'b0000000, base};
        return wide << n;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/i2cdiv_sequencer.sv */
`default_nettype none

module i2cdiv_sequencer
    import i2cdiv_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire status_t status,
    output ctrl_t        ctrl,
    output logic         busy
);

    logic [PC_W-1:0] pc_reg;
    logic [PC_W-1:0] pc_next;
    uword_t          uw;
    logic            take;

    always_comb
    begin
        uw = rom_f(pc_reg);
        unique case (uw.cond)
            COND_NEXT:       take = 1'b0;
            COND_IDLE:       take = !start;
            COND_DIV_MORE:   take = status.div_more;
            COND_MORE_CANDS: take = status.more_cands;
            COND_ALWAYS:     take = 1'b1;
            default:         take = 1'b1;
        endcase
        pc_next = take ? uw.target : pc_reg + 3'd1;
        ctrl.op = (uw.op == OP_LOAD && !start) ? OP_NOP : uw.op;
    end

    assign busy = (pc_reg != STEP_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // a word leaves the divider loop only into the compare step
    a_div_exit: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == STEP_DIV && !status.div_more) |=> (pc_reg == STEP_CMP))
        else $error("divider loop exit went astray");

endmodule

`default_nettype wire

/* rtl/core/i2cdiv_datapath.sv */
`default_nettype none

module i2cdiv_datapath
    import i2cdiv_pkg::*;
#(
    parameter int unsigned M_MAX = 15,
    parameter int unsigned N_MAX = 7
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire ctrl_t             ctrl,
    input  wire logic              cfg_wr_en,
    input  wire logic [CLK_W-1:0]  cfg_wr_data,
    input  wire logic [RATE_W-1:0] target_rate,
    output status_t                status,
    output logic [6:0]             divider_word,
    output logic                   found,
    output logic                   done
);

    localparam logic [3:0] M_LAST = 4'(M_MAX);
    localparam logic [2:0] N_LAST = 3'(N_MAX);

    logic [CLK_W-1:0]     clk_hz_reg;
    logic [RATE_W-1:0]    target_reg;
    logic [3:0]           m_reg;
    logic [2:0]           n_reg;
    logic [DIVISOR_W-1:0] divisor_reg;
    logic [DIVISOR_W-1:0] rem_reg;
    logic [CLK_W-1:0]     quo_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [RATE_W-1:0]    best_gap_reg;
    logic [3:0]           win_m_reg;
    logic [2:0]           win_n_reg;
    logic                 have_reg;
    logic                 exact_reg;
    logic [6:0]           word_reg;
    logic                 found_reg;
    logic                 done_reg;

    logic [DIVISOR_W:0]   rem_shift;
    logic                 sub_ok;
    logic [DIVISOR_W:0]   rem_diff;
    logic [CLK_W-1:0]     target_ext;
    logic                 qualify;
    logic [RATE_W-1:0]    gap;
    logic                 better;
    logic                 last_pair;
    logic [3:0]           m_adv;
    logic [2:0]           n_adv;

    always_comb
    begin
        rem_shift  = {rem_reg, quo_reg[CLK_W-1]};
        rem_diff   = rem_shift - {1'b0, divisor_reg};
        sub_ok     = (rem_shift >= {1'b0, divisor_reg});
        target_ext = {{(CLK_W-RATE_W){1'b0}}, target_reg};
        qualify    = (target_ext >= quo_reg);
        gap        = target_reg - quo_reg[RATE_W-1:0];
        better     = qualify && (!have_reg || gap < best_gap_reg);
        last_pair  = (m_reg == M_LAST) && (n_reg == N_LAST);
        if (m_reg == M_LAST)
        begin
            m_adv = 4'd0;
            n_adv = n_reg + 3'd1;
        end
        else
        begin
            m_adv = m_reg + 4'd1;
            n_adv = n_reg;
        end
        status.div_more   = (cnt_reg != DIV_LAST);
        status.more_cands = !(exact_reg || last_pair);
    end

    // config register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clk_hz_reg <= CLK_RESET;
        end
        else if (cfg_wr_en)
        begin
            clk_hz_reg <= cfg_wr_data;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg  <= 1'b0;
            exact_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= (ctrl.op == OP_EMIT);
            if (ctrl.op == OP_LOAD)
            begin
                have_reg  <= 1'b0;
                exact_reg <= 1'b0;
            end
            else if (ctrl.op == OP_CMP && better)
            begin
                have_reg  <= 1'b1;
                exact_reg <= (gap == '0);
            end
        end
    end

    // datapath payload
    always_ff @(posedge clk)
    begin
        unique case (ctrl.op)
            OP_LOAD:
            begin
                target_reg  <= target_rate;
                m_reg       <= 4'd0;
                n_reg       <= 3'd0;
                divisor_reg <= divisor_f(4'd0, 3'd0);
                rem_reg     <= '0;
                quo_reg     <= clk_hz_reg;
                cnt_reg     <= '0;
                win_m_reg   <= DEFAULT_M;
                win_n_reg   <= DEFAULT_N;
            end
            OP_DIV:
            begin
                rem_reg <= sub_ok ? rem_diff[DIVISOR_W-1:0] : rem_shift[DIVISOR_W-1:0];
                quo_reg <= {quo_reg[CLK_W-2:0], sub_ok};
                cnt_reg <= cnt_reg + 5'd1;
            end
            OP_CMP:
            begin
                if (better)
                begin
                    best_gap_reg <= gap;
                    win_m_reg    <= m_reg;
                    win_n_reg    <= n_reg;
                end
            end
            OP_STEP:
            begin
                m_reg       <= m_adv;
                n_reg       <= n_adv;
                divisor_reg <= divisor_f(m_adv, n_adv);
                rem_reg     <= '0;
                quo_reg     <= clk_hz_reg;
                cnt_reg     <= '0;
            end
            OP_EMIT:
            begin
                word_reg  <= {win_m_reg, win_n_reg};
                found_reg <= have_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign divider_word = word_reg;
    assign found        = found_reg;
    assign done         = done_reg;

    a_exact_has: assert property (@(posedge clk) disable iff (!rst_n)
        exact_reg |-> have_reg)
        else $error("exact match without a winner");

    a_emit_found: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.op == OP_EMIT) |=> (done_reg && found_reg == $past(have_reg)))
        else $error("found flag does not follow the search");

endmodule

`default_nettype wire

/* rtl/core/i2c_clock_divider_search_unit.sv */
`default_nettype none
// done rises once the search started by a taken start has tried k pairs, k from 1 to 128
// each pair runs the 30-bit bit-serial divider plus one compare and one step
// a new word is taken only while idle; start is taken again in the done cycle
// done is a one-cycle strobe and the receiver cannot stall it
// reset: sequencer goes idle, source clock register returns to 100 MHz

module i2c_clock_divider_search_unit
    import i2cdiv_pkg::*;
#(
    parameter int unsigned M_MAX = 15,
    parameter int unsigned N_MAX = 7
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [CLK_W-1:0]  cfg_wr_data,
    input  wire logic              start,
    input  wire logic [RATE_W-1:0] target_rate,
    output logic                   busy,
    output logic                   done,
    output logic [6:0]             divider_word,
    output logic                   found
);

    ctrl_t   ctrl;
    status_t status;

    i2cdiv_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .busy   (busy)
    );

    i2cdiv_datapath #(
        .M_MAX (M_MAX),
        .N_MAX (N_MAX)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .target_rate  (target_rate),
        .status       (status),
        .divider_word (divider_word),
        .found        (found),
        .done         (done)
    );

    a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("word taken but unit not busy");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (!busy && !$past(done)))
        else $error("result strobe while busy or repeated");

endmodule

`default_nettype wire

/* verif/testbench.sv */
`timescale 1ns / 100ps

module testbench;
    import i2cdiv_pkg::*;

    localparam int unsigned SEARCH_M_LAST = 15;
    localparam int unsigned SEARCH_N_LAST = 7;
    localparam int unsigned RANDOM_PHASES = 5;
    localparam int unsigned PHASE_WORDS   = 24;
    localparam int unsigned QUIET_FIRST   = 60;
    localparam int unsigned QUIET_LAST    = 95;
    localparam int unsigned DIRECTED_ROWS = 25;

    localparam logic [6:0] FALLBACK_WORD = {DEFAULT_M, DEFAULT_N};
    localparam logic [6:0] FIRST_WORD    = 7'd0;
    localparam logic [6:0] LAST_WORD     = {4'd15, 3'd7};
    localparam logic [RATE_W-1:0] RATE_ALL  = '1;
    localparam logic [CLK_W-1:0]  CLOCK_ALL = '1;

    typedef struct packed {
        logic [6:0] divider_word;
        logic       found;
    } divider_result_t;

    typedef struct packed {
        logic              is_cfg;
        logic [CLK_W-1:0]  clk_hz;
        logic [RATE_W-1:0] rate;
        logic              typed;
        logic [6:0]        divider_word;
        logic              found;
    } directed_row_t;

    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{1'b0, 30'd0,     26'd0,         1'b1, FALLBACK_WORD, 1'b0},
        '{1'b0, 30'd0,     RATE_ALL,      1'b1, FIRST_WORD,    1'b1},
        '{1'b0, 30'd0,     26'd10000000,  1'b1, FIRST_WORD,    1'b1},
        '{1'b0, 30'd0,     26'd4882,      1'b1, LAST_WORD,     1'b1},
        '{1'b0, 30'd0,     26'd4881,      1'b1, FALLBACK_WORD, 1'b0},
        '{1'b0, 30'd0,     26'd5000000,   1'b0, FIRST_WORD,    1'b0},
        '{1'b0, 30'd0,     26'd4999999,   1'b0, FIRST_WORD,    1'b0},
        '{1'b0, 30'd0,     26'd100000,    1'b0, FIRST_WORD,    1'b0},
        '{1'b0, 30'd0,     26'd400000,    1'b0, FIRST_WORD,    1'b0},
        '{1'b0, 30'd0,     26'h2AAAAAA,   1'b0, FIRST_WORD,    1'b0},
        '{1'b0, 30'd0,     26'h1555555,   1'b0, FIRST_WORD,    1'b0},
        '{1'b1, 30'd0,     26'd0,         1'b0, FIRST_WORD,    1'b0},
        '{1'b0, 30'd0,     26'd0,         1'b1, FIRST_WORD,    1'b1},
        '{1'b0, 30'd0,     RATE_ALL,      1'b1, FIRST_WORD,    1'b1},
        '{1'b1, 30'd1,     26'd0,         1'b0, FIRST_WORD,    1'b0},
        '{1'b0, 30'd0,     26'h1555555,   1'b1, FIRST_WORD,    1'b1},
        '{1'b1, CLOCK_ALL, 26'd0,         1'b0, FIRST_WORD,    1'b0},
        '{1'b0, 30'd0,     26'd0,         1'b1, FALLBACK_WORD, 1'b0},
        '{1'b0, 30'd0,     RATE_ALL,      1'b0, FIRST_WORD,    1'b0},
        '{1'b0, 30'd0,     26'd104857,    1'b0, FIRST_WORD,    1'b0},
        '{1'b1, 30'd20,    26'd0,         1'b0, FIRST_WORD,    1'b0},
        '{1'b0, 30'd0,     26'd1,         1'b0, FIRST_WORD,    1'b0},
        '{1'b0, 30'd0,     26'd2,         1'b1, FIRST_WORD,    1'b1},
        '{1'b1, CLK_RESET, 26'd0,         1'b0, FIRST_WORD,    1'b0},
        '{1'b0, 30'd0,     26'd333333,    1'b0, FIRST_WORD,    1'b0}
    };

    logic              clk;
    logic              rst_n;
    logic              cfg_wr_en;
    logic [CLK_W-1:0]  cfg_wr_data;
    logic              start;
    logic [RATE_W-1:0] target_rate;
    logic              busy;
    logic              done;
    logic [6:0]        divider_word;
    logic              found;

    logic [CLK_W-1:0]  source_clock;
    divider_result_t   pending_dividers [$];
    divider_result_t   oldest_divider;
    int unsigned       errors;
    int unsigned       words_sent;

    i2c_clock_divider_search_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .start        (start),
        .target_rate  (target_rate),
        .busy         (busy),
        .done         (done),
        .divider_word (divider_word),
        .found        (found)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #30_000_000;
        $display("i2c_clock_divider_search_unit: mismatch");
        $finish;
    end

    function automatic divider_result_t search_divider(input logic [CLK_W-1:0] clk_hz,
                                                       input logic [RATE_W-1:0] rate);
        divider_result_t res;
        int unsigned     divisor;
        int unsigned     cand;
        int unsigned     shortfall;
        int unsigned     best;
        logic            exact;
        res.divider_word = FALLBACK_WORD;
        res.found        = 1'b0;
        best             = 0;
        exact            = 1'b0;
        for (int unsigned n = 0; n <= SEARCH_N_LAST && !exact; n++)
        begin
            for (int unsigned m = 0; m <= SEARCH_M_LAST && !exact; m++)
            begin
                divisor = (10 * (m + 1)) << n;
                cand    = int'(clk_hz) / divisor;
                if (int'(rate) >= cand)
                begin
                    shortfall = int'(rate) - cand;
                    if (!res.found || shortfall < best)
                    begin
                        res.found        = 1'b1;
                        best             = shortfall;
                        res.divider_word = {4'(m), 3'(n)};
                        exact            = (shortfall == 0);
                    end
                end
            end
        end
        return res;
    endfunction

    // mostly rates on or next to a candidate of the current clock
    function automatic logic [RATE_W-1:0] pick_rate(input logic [CLK_W-1:0] clk_hz);
        int unsigned sel;
        longint      cand;
        longint      r;
        sel  = $urandom_range(0, 99);
        cand = longint'(clk_hz) /
               longint'((10 * ($urandom_range(0, SEARCH_M_LAST) + 1))
                        << $urandom_range(0, SEARCH_N_LAST));
        if (sel < 35)
            r = cand;
        else if (sel < 55)
            r = cand + longint'($urandom_range(0, 6)) - 3;
        else if (sel < 75)
            r = longint'($urandom_range(0, int'(RATE_ALL)));
        else if (sel < 90)
            r = longint'($urandom_range(0, int'(clk_hz) / 20480 + 2));
        else if (sel < 95)
            r = longint'(RATE_ALL);
        else
            r = longint'(1) << $urandom_range(0, RATE_W - 1);
        if (r < 0)
            r = 0;
        if (r > longint'(RATE_ALL))
            r = longint'(RATE_ALL);
        return r[RATE_W-1:0];
    endfunction

    function automatic int unsigned sender_gap(input logic quiet);
        if (quiet || $urandom_range(0, 99) >= 28)
            return 0;
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(20, 200);
        return $urandom_range(1, 4);
    endfunction

    task automatic send_rate(input logic [RATE_W-1:0] rate, input logic typed,
                             input divider_result_t typed_result);
        divider_result_t predicted;
        predicted    = search_divider(source_clock, rate);
        start       <= 1'b1;
        target_rate <= rate;
        do
            @(posedge clk);
        while (busy);
        pending_dividers.push_back(typed ? typed_result : predicted);
        words_sent++;
    endtask

    task automatic settle();
        start <= 1'b0;
        while (pending_dividers.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_source_clock(input logic [CLK_W-1:0] value);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en    <= 1'b0;
        source_clock  = value;
    endtask

    // result check
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_dividers.size() == 0)
            begin
                $display("%0t unexpected word: expected none, actual divider_word %0d found %0b",
                         $time, divider_word, found);
                errors++;
            end
            else
            begin
                oldest_divider = pending_dividers.pop_front();
                if (divider_word !== oldest_divider.divider_word)
                begin
                    $display("%0t divider_word: expected %0d, actual %0d",
                             $time, oldest_divider.divider_word, divider_word);
                    errors++;
                end
                if (found !== oldest_divider.found)
                begin
                    $display("%0t found: expected %0b, actual %0b",
                             $time, oldest_divider.found, found);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int unsigned       gap;
        int unsigned       random_words;
        logic [CLK_W-1:0]  phase_clock;
        directed_row_t     row;
        errors       = 0;
        words_sent   = 0;
        random_words = 0;
        source_clock = CLK_RESET;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        start       <= 1'b0;
        target_rate <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_ROWS; i++)
        begin
            row = DIRECTED[i];
            if (row.is_cfg)
                write_source_clock(row.clk_hz);
            else
                send_rate(row.rate, row.typed, '{row.divider_word, row.found});
        end

        for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase)
                0: phase_clock = 30'd24000000;
                1: phase_clock = CLK_W'($urandom_range(1, int'(CLOCK_ALL)));
                2: phase_clock = 30'd1000000000;
                3: phase_clock = 30'd66000000;
                default: phase_clock = CLK_RESET;
            endcase
            write_source_clock(phase_clock);
            for (int unsigned k = 0; k < PHASE_WORDS; k++)
            begin
                send_rate(pick_rate(source_clock), 1'b0, '0);
                random_words++;
                gap = sender_gap(random_words >= QUIET_FIRST && random_words <= QUIET_LAST);
                if (gap != 0)
                begin
                    start <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        settle();
        repeat (200) @(posedge clk);
        if (errors == 0)
            $display("i2c_clock_divider_search_unit: match");
        else
            $display("i2c_clock_divider_search_unit: mismatch");
        $finish;
    end

endmodule
